// ----- sv/mi4_pkg.sv -----
// mi4_pkg: shared types, state codes and index helpers for the 4x4 inverse
// depends on nothing; used by mi4_back and the top level
package mi4_pkg;

    localparam int FIELD_W = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MINOR,
        S_MFIN,
        S_DMUL,
        S_DFIN,
        S_CHECK,
        S_DIV_INIT,
        S_DIV,
        S_DRES,
        S_EMIT
    } mi4_state_t;

    typedef struct packed {
        logic       en;
        logic       to_det;
        logic       sub;
        logic [1:0] shift;
    } mi4_pend_t;

    function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] j);
        logic [1:0] c;
        case (t)
            3'd0: c = j;
            3'd1: c = (j == 2'd0) ? 2'd1 : ((j == 2'd1) ? 2'd2 : 2'd0);
            3'd2: c = (j == 2'd0) ? 2'd2 : ((j == 2'd1) ? 2'd0 : 2'd1);
            3'd3: c = (j == 2'd0) ? 2'd2 : ((j == 2'd1) ? 2'd1 : 2'd0);
            3'd4: c = (j == 2'd0) ? 2'd1 : ((j == 2'd1) ? 2'd0 : 2'd2);
            3'd5: c = (j == 2'd0) ? 2'd0 : ((j == 2'd1) ? 2'd2 : 2'd1);
            default: c = j;
        endcase
        return c;
    endfunction

    function automatic logic term_sub(input logic [2:0] t);
        return (t >= 3'd3);
    endfunction

    function automatic logic [1:0] skip_idx(input logic [1:0] j, input logic [1:0] rm);
        return (j < rm) ? j : (j + 2'd1);
    endfunction

endpackage

// ----- sv/mi4_queue.sv -----
// mi4_queue: two-entry queue of whole matrices between front and back
// depends on nothing
module mi4_queue #(
    parameter int DATA_W = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              push_go;
    logic              pop_go;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_go    = push_valid && push_ready;
    assign pop_go     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push_go)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop_go)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push_go && !pop_go)
                count_reg <= count_reg + 2'd1;
            else if (pop_go && !push_go)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_go)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- sv/mi4_front.sv -----
// mi4_front: collects four column beats into a matrix and pushes it to the queue
// depends on nothing; pushes through the downstream handshake that mi4_queue answers
module mi4_front #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ELEM_WIDTH-1:0]      col_elem [4],
    output logic                       push_valid,
    input  logic                       push_ready,
    output logic [16*ELEM_WIDTH-1:0]   push_data
);

    logic [1:0]            cnt_reg;
    logic [ELEM_WIDTH-1:0] stage_reg [4][3];
    logic                  in_go;

    assign in_ready   = (cnt_reg != 2'd3) || push_ready;
    assign in_go      = in_valid && in_ready;
    assign push_valid = in_valid && (cnt_reg == 2'd3);

    // element (row, col) sits at row*4+col
    always_comb
    begin
        for (int row = 0; row < 4; row++)
        begin
            for (int col = 0; col < 3; col++)
                push_data[(row*4+col)*ELEM_WIDTH +: ELEM_WIDTH] = stage_reg[row][col];
            push_data[(row*4+3)*ELEM_WIDTH +: ELEM_WIDTH] = col_elem[row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (in_go)
            cnt_reg <= cnt_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (in_go && (cnt_reg != 2'd3))
        begin
            for (int row = 0; row < 4; row++)
                stage_reg[row][cnt_reg] <= col_elem[row];
        end
    end

endmodule

// ----- sv/mi4_back.sv -----
// mi4_back: cofactor, determinant and division sequencer with the result register
// depends on mi4_pkg; fed by mi4_queue
module mi4_back
    import mi4_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  logic [16*ELEM_WIDTH-1:0]  q_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [FIELD_W-1:0]        out_row [4],
    output logic                      out_last,
    output logic                      out_sing
);

    localparam int W    = ELEM_WIDTH;
    localparam int MW   = 3*W + 3;
    localparam int DW   = 4*W + 4;
    localparam int PW   = 2*W + 1;
    localparam int NUMW = MW + 2*FRAC_BITS;
    localparam int HIW  = NUMW - W;
    localparam int CW   = (HIW > DW) ? HIW : DW;
    localparam int CNTW = $clog2(W);

    mi4_state_t state_reg, state_next;
    logic [2:0]      t_reg, t_next;
    logic [1:0]      s_reg, s_next;
    logic [1:0]      r_reg, r_next;
    logic [1:0]      k_reg, k_next;
    logic            det_mode_reg, det_mode_next;
    logic            sing_reg, sing_next;
    logic [CNTW-1:0] div_cnt_reg, div_cnt_next;
    mi4_pend_t       pend_reg, pend_next;
    logic            out_valid_reg, out_valid_next;
    logic            emit_go;

    logic [W-1:0]          m_reg [16];
    logic [W-1:0]          xa_reg;
    logic [W-1:0]          phi_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [MW-1:0]  macc_reg;
    logic signed [DW-1:0]  dacc_reg;
    logic [DW-1:0]         den_reg;
    logic                  dneg_reg;
    logic [DW-1:0]         rem_reg;
    logic [W-1:0]          lo_reg;
    logic [W-1:0]          q_reg;
    logic                  ovf_reg;
    logic                  neg_reg;
    logic [W-1:0]          res_reg [4];
    logic [FIELD_W-1:0]    row_reg [4];
    logic                  last_reg;
    logic                  osing_reg;

    logic [1:0]             j_sel, sr, sc, rd_row, rd_col;
    logic signed [W-1:0]    elem;
    logic signed [W:0]      mul_x;
    logic signed [PW-1:0]   mul_p;
    logic signed [4*W-1:0]  macc_ext;
    logic signed [DW-1:0]   prod_ext;
    logic signed [DW-1:0]   shv;
    logic signed [DW-1:0]   addend;
    logic signed [MW-1:0]   cof;
    logic [MW-1:0]          cmag;
    logic [NUMW-1:0]        num;
    logic [CW-1:0]          hi_ext;
    logic [CW-1:0]          den_ext;
    logic [DW:0]            trial_in;
    logic [DW:0]            trial_diff;
    logic                   trial_ge;
    logic [W-1:0]           sat_val;
    logic [W-1:0]           max_pos;
    logic [W-1:0]           min_neg;

    // element read port
    always_comb
    begin
        j_sel = (s_reg == 2'd0) ? 2'd0 : ((s_reg == 2'd1) ? 2'd1 : 2'd2);
        sr    = det_mode_reg ? r_reg : k_reg;
        sc    = det_mode_reg ? 2'd0 : r_reg;
        if (state_reg == S_DMUL)
        begin
            rd_row = r_reg;
            rd_col = 2'd0;
        end
        else
        begin
            rd_row = skip_idx(j_sel, sr);
            rd_col = skip_idx(perm_col(t_reg, j_sel), sc);
        end
        elem = signed'(m_reg[{rd_row, rd_col}]);
    end

    // shared multiplier
    always_comb
    begin
        macc_ext = (4*W)'(macc_reg);
        mul_x    = '0;
        if (state_reg == S_MINOR)
        begin
            case (s_reg)
                2'd1:    mul_x = signed'({xa_reg[W-1], xa_reg});
                2'd2:    mul_x = signed'({1'b0, prod_reg[W-1:0]});
                2'd3:    mul_x = signed'({phi_reg[W-1], phi_reg});
                default: mul_x = '0;
            endcase
        end
        else if (state_reg == S_DMUL)
        begin
            case (s_reg)
                2'd0:    mul_x = signed'({1'b0, macc_ext[W-1:0]});
                2'd1:    mul_x = signed'({1'b0, macc_ext[2*W-1:W]});
                2'd2:    mul_x = signed'({1'b0, macc_ext[3*W-1:2*W]});
                default: mul_x = signed'({macc_ext[4*W-1], macc_ext[4*W-1:3*W]});
            endcase
        end
        mul_p = mul_x * elem;
    end

    // accumulate path
    always_comb
    begin
        prod_ext = DW'(prod_reg);
        case (pend_reg.shift)
            2'd0:    shv = prod_ext;
            2'd1:    shv = prod_ext <<< W;
            2'd2:    shv = prod_ext <<< (2*W);
            default: shv = prod_ext <<< (3*W);
        endcase
        addend = pend_reg.sub ? -shv : shv;
    end

    // divider set-up, step and saturation
    always_comb
    begin
        cof        = (k_reg[0] ^ r_reg[0]) ? -macc_reg : macc_reg;
        cmag       = cof[MW-1] ? unsigned'(-cof) : unsigned'(cof);
        num        = {cmag, {(2*FRAC_BITS){1'b0}}};
        hi_ext     = CW'(num[NUMW-1:W]);
        den_ext    = CW'(den_reg);
        trial_in   = {rem_reg, lo_reg[W-1]};
        trial_ge   = (trial_in >= {1'b0, den_reg});
        trial_diff = trial_in - {1'b0, den_reg};
        max_pos    = {1'b0, {(W-1){1'b1}}};
        min_neg    = {1'b1, {(W-1){1'b0}}};
        if (ovf_reg)
            sat_val = neg_reg ? min_neg : max_pos;
        else if (!neg_reg)
            sat_val = (q_reg > max_pos) ? max_pos : q_reg;
        else
            sat_val = (q_reg > min_neg) ? min_neg : (W'(0) - q_reg);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        r_next         = r_reg;
        k_next         = k_reg;
        det_mode_next  = det_mode_reg;
        sing_next      = sing_reg;
        div_cnt_next   = div_cnt_reg;
        pend_next      = '0;
        q_ready        = 1'b0;
        emit_go        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_ready       = 1'b1;
                    det_mode_next = 1'b1;
                    r_next        = 2'd0;
                    k_next        = 2'd0;
                    t_next        = 3'd0;
                    s_next        = 2'd0;
                    state_next    = S_MINOR;
                end
            end
            S_MINOR:
            begin
                if (s_reg == 2'd2)
                    pend_next = '{en: 1'b1, to_det: 1'b0, sub: term_sub(t_reg), shift: 2'd0};
                else if (s_reg == 2'd3)
                    pend_next = '{en: 1'b1, to_det: 1'b0, sub: term_sub(t_reg), shift: 2'd1};
                s_next = s_reg + 2'd1;
                if (s_reg == 2'd3)
                begin
                    if (t_reg == 3'd5)
                    begin
                        t_next     = 3'd0;
                        state_next = S_MFIN;
                    end
                    else
                        t_next = t_reg + 3'd1;
                end
            end
            S_MFIN:
            begin
                s_next     = 2'd0;
                state_next = det_mode_reg ? S_DMUL : S_DIV_INIT;
            end
            S_DMUL:
            begin
                pend_next = '{en: 1'b1, to_det: 1'b1, sub: r_reg[0], shift: s_reg};
                s_next    = s_reg + 2'd1;
                if (s_reg == 2'd3)
                    state_next = S_DFIN;
            end
            S_DFIN:
            begin
                if (r_reg == 2'd3)
                    state_next = S_CHECK;
                else
                begin
                    r_next     = r_reg + 2'd1;
                    state_next = S_MINOR;
                end
            end
            S_CHECK:
            begin
                det_mode_next = 1'b0;
                r_next        = 2'd0;
                k_next        = 2'd0;
                sing_next     = (dacc_reg == '0);
                state_next    = (dacc_reg == '0) ? S_EMIT : S_MINOR;
            end
            S_DIV_INIT:
            begin
                div_cnt_next = CNTW'(W-1);
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                div_cnt_next = div_cnt_reg - CNTW'(1);
                if (div_cnt_reg == '0)
                    state_next = S_DRES;
            end
            S_DRES:
            begin
                if (r_reg == 2'd3)
                    state_next = S_EMIT;
                else
                begin
                    r_next     = r_reg + 2'd1;
                    state_next = S_MINOR;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    emit_go = 1'b1;
                    if (k_reg == 2'd3)
                        state_next = S_IDLE;
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        r_next     = 2'd0;
                        state_next = sing_reg ? S_EMIT : S_MINOR;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (emit_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            t_reg         <= 3'd0;
            s_reg         <= 2'd0;
            r_reg         <= 2'd0;
            k_reg         <= 2'd0;
            det_mode_reg  <= 1'b0;
            sing_reg      <= 1'b0;
            div_cnt_reg   <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            s_reg         <= s_next;
            r_reg         <= r_next;
            k_reg         <= k_next;
            det_mode_reg  <= det_mode_next;
            sing_reg      <= sing_next;
            div_cnt_reg   <= div_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg.en)
        begin
            if (pend_reg.to_det)
                dacc_reg <= dacc_reg + addend;
            else
                macc_reg <= macc_reg + addend[MW-1:0];
        end
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    for (int i = 0; i < 16; i++)
                        m_reg[i] <= q_data[i*W +: W];
                    dacc_reg <= '0;
                end
            end
            S_MINOR:
            begin
                case (s_reg)
                    2'd0:
                    begin
                        xa_reg <= elem;
                        if (t_reg == 3'd0)
                            macc_reg <= '0;
                    end
                    2'd2:
                    begin
                        phi_reg  <= prod_reg[2*W-1:W];
                        prod_reg <= mul_p;
                    end
                    default: prod_reg <= mul_p;
                endcase
            end
            S_DMUL: prod_reg <= mul_p;
            S_CHECK:
            begin
                dneg_reg <= dacc_reg[DW-1];
                den_reg  <= dacc_reg[DW-1] ? unsigned'(-dacc_reg) : unsigned'(dacc_reg);
            end
            S_DIV_INIT:
            begin
                ovf_reg <= (hi_ext >= den_ext);
                rem_reg <= hi_ext[DW-1:0];
                lo_reg  <= num[W-1:0];
                neg_reg <= cof[MW-1] ^ dneg_reg;
                q_reg   <= '0;
            end
            S_DIV:
            begin
                rem_reg <= trial_ge ? trial_diff[DW-1:0] : trial_in[DW-1:0];
                q_reg   <= {q_reg[W-2:0], trial_ge};
                lo_reg  <= {lo_reg[W-2:0], 1'b0};
            end
            S_DRES: res_reg[r_reg] <= sat_val;
            S_EMIT:
            begin
                if (emit_go)
                begin
                    for (int i = 0; i < 4; i++)
                        row_reg[i] <= sing_reg ? '0 : FIELD_W'(res_reg[i]);
                    last_reg  <= (k_reg == 2'd3);
                    osing_reg <= sing_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_row   = row_reg;
    assign out_last  = last_reg;
    assign out_sing  = osing_reg;

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_reg.en)
        else $error("accumulate pending while idle");

    a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (den_reg != '0))
        else $error("division with zero divisor");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> out_valid_reg)
        else $error("emitted column not presented");

    a_queue_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> ((state_reg == S_IDLE) && q_valid))
        else $error("matrix popped while busy");

endmodule

// ----- sv/mat4_inverse_adjugate.sv -----
// mat4_inverse_adjugate: 4x4 fixed-point inverse by cofactors, top level
// depends on mi4_pkg, mi4_front, mi4_queue and mi4_back
//
// channel  | handshake           | payload
// input    | in_valid, in_ready  | col_row0..col_row3, one matrix column per beat
// output   | out_valid,out_ready | inv_row0..inv_row3, last_column, singular
//
// columns are taken one a cycle while the two-matrix queue has room
// one matrix at a time passes through the back end, paced by the single shared multiplier
// and the one-bit-per-cycle divider
// a singular matrix skips the cofactor and divide passes
// the result register lets the back end start the next column while one waits
// rst_n clears all control state; stored elements need no reset
module mat4_inverse_adjugate
    import mi4_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FIELD_W-1:0] col_row0,
    input  logic [FIELD_W-1:0] col_row1,
    input  logic [FIELD_W-1:0] col_row2,
    input  logic [FIELD_W-1:0] col_row3,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FIELD_W-1:0] inv_row0,
    output logic [FIELD_W-1:0] inv_row1,
    output logic [FIELD_W-1:0] inv_row2,
    output logic [FIELD_W-1:0] inv_row3,
    output logic               last_column,
    output logic               singular
);

    logic [ELEM_WIDTH-1:0]   col_elem [4];
    logic                    push_valid;
    logic                    push_ready;
    logic [16*ELEM_WIDTH-1:0] push_data;
    logic                    pop_valid;
    logic                    pop_ready;
    logic [16*ELEM_WIDTH-1:0] pop_data;
    logic [FIELD_W-1:0]      out_row [4];

    assign col_elem[0] = col_row0[ELEM_WIDTH-1:0];
    assign col_elem[1] = col_row1[ELEM_WIDTH-1:0];
    assign col_elem[2] = col_row2[ELEM_WIDTH-1:0];
    assign col_elem[3] = col_row3[ELEM_WIDTH-1:0];

    mi4_front #(
        .ELEM_WIDTH(ELEM_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .col_elem  (col_elem),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data)
    );

    mi4_queue #(
        .DATA_W(16*ELEM_WIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    mi4_back #(
        .ELEM_WIDTH(ELEM_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (pop_valid),
        .q_ready  (pop_ready),
        .q_data   (pop_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_row  (out_row),
        .out_last (last_column),
        .out_sing (singular)
    );

    assign inv_row0 = out_row[0];
    assign inv_row1 = out_row[1];
    assign inv_row2 = out_row[2];
    assign inv_row3 = out_row[3];

endmodule
